### design/assert_macros.svh
// Assertion macros used by the tracker top level.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
// Users must have signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/prlt_pkg.sv
// Package for the peer reputation LRU tracker: sequencer states, mode and
// register codes, reset values and the table entry layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prlt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_TIER,
      ST_FINAL,
      ST_RESP
   } state_type;

   // transaction modes
   localparam logic [1:0] MODE_CHECK = 2'd0;
   localparam logic [1:0] MODE_EST   = 2'd1;
   localparam logic [1:0] MODE_CLEAN = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_BASE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_CONG = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_HARD = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MAX  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAN_AGE      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LEVEL    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LEVEL   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOD_LEVEL  = 4'd7;

   // register reset values
   localparam logic [31:0] RST_TIMEOUT_BASE = 32'd50000;
   localparam logic [31:0] RST_TIMEOUT_CONG = 32'd100000;
   localparam logic [31:0] RST_TIMEOUT_HARD = 32'd500000;
   localparam logic [31:0] RST_TIMEOUT_MAX  = 32'd3000000;
   localparam logic [31:0] RST_BAN_AGE      = 32'd30000000;
   localparam logic [7:0]  RST_MID_LEVEL    = 8'd3;
   localparam logic [7:0]  RST_HIGH_LEVEL   = 8'd6;
   localparam logic [7:0]  RST_FLOOD_LEVEL  = 8'd10;

   localparam logic [63:0] STALE_LIMIT_US = 64'd3600000000;
   localparam logic [63:0] NO_TIME        = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [7:0]  FAIL_SAT       = 8'd255;

   typedef struct packed {
      logic [31:0] address;
      logic [63:0] last_seen;
      logic [7:0]  failures;
      logic [63:0] handshake;
   } entry_type;

endpackage

`default_nettype wire

### design/peer_reputation_lru_tracker.sv
// Peer reputation LRU tracker, top level: sequencer, table memory, CSRs.
// Depends on prlt_pkg and assert_macros.svh.
// ---------------------------------------------------------------------------
// Usage:
//  - Request channel: a transaction is taken at a rising edge with start high
//    and busy low. req_mode selects check (0), established (1), cleanup (2).
//  - Response channel: rsp_valid is high for one cycle per transaction with
//    the result on the rsp_ ports. The receiver cannot stall; a result that
//    is not taken in that cycle is gone.
//  - CSR port: csr_we writes csr_wdata to register csr_index;
//    indexes above 7 are dropped. Write only while busy is low.
//  - Check/established: scan, fetch, tier, write-back and response. Cleanup:
//    scan, then response. Mode 3: response only, no scan. busy stays high
//    through the write-back or response state, so no new transaction is taken before it.
//  - Rate is set by the table scan: one entry per cycle through the single
//    read port of the table memory and one shared compare unit; check and
//    established add a re-read of the chosen entry, a tier and a write-back stage.
//  - Reset clears the CSRs to defaults, the sequencer and the per-entry valid
//    bits; an entry whose valid bit is clear reads as all zero (empty).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module peer_reputation_lru_tracker #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_mode,
   input  wire logic [31:0]                      req_peer_ip,
   input  wire logic [63:0]                      req_now_us,
   input  wire logic [63:0]                      req_handshake_age_us,
   input  wire logic                             req_had_start,
   output logic                                  rsp_valid,
   output logic [3:0]                            rsp_slot,
   output logic                                  rsp_was_new,
   output logic                                  rsp_timed_out,
   output logic                                  rsp_ban_request,
   output logic [7:0]                            rsp_fail_count,
   output logic [31:0]                           rsp_timeout_used_us,
   output logic [63:0]                           rsp_stored_handshake_us,
   input  wire logic                             csr_we,
   input  wire logic [prlt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                      csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

   // ---------------- CSRs ----------------
   logic [31:0] tmo_base_ff, tmo_cong_ff, tmo_hard_ff, tmo_max_ff, ban_age_ff;
   logic [7:0]  mid_lvl_ff, high_lvl_ff, flood_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_base_ff  <= prlt_pkg::RST_TIMEOUT_BASE;
         tmo_cong_ff  <= prlt_pkg::RST_TIMEOUT_CONG;
         tmo_hard_ff  <= prlt_pkg::RST_TIMEOUT_HARD;
         tmo_max_ff   <= prlt_pkg::RST_TIMEOUT_MAX;
         ban_age_ff   <= prlt_pkg::RST_BAN_AGE;
         mid_lvl_ff   <= prlt_pkg::RST_MID_LEVEL;
         high_lvl_ff  <= prlt_pkg::RST_HIGH_LEVEL;
         flood_lvl_ff <= prlt_pkg::RST_FLOOD_LEVEL;
      end else if (csr_we) begin
         unique case (csr_index)
            prlt_pkg::CSR_TIMEOUT_BASE: tmo_base_ff  <= csr_wdata;
            prlt_pkg::CSR_TIMEOUT_CONG: tmo_cong_ff  <= csr_wdata;
            prlt_pkg::CSR_TIMEOUT_HARD: tmo_hard_ff  <= csr_wdata;
            prlt_pkg::CSR_TIMEOUT_MAX:  tmo_max_ff   <= csr_wdata;
            prlt_pkg::CSR_BAN_AGE:      ban_age_ff   <= csr_wdata;
            prlt_pkg::CSR_MID_LEVEL:    mid_lvl_ff   <= csr_wdata[7:0];
            prlt_pkg::CSR_HIGH_LEVEL:   high_lvl_ff  <= csr_wdata[7:0];
            prlt_pkg::CSR_FLOOD_LEVEL:  flood_lvl_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer state ----------------
   prlt_pkg::state_type state_ff, state_in;
   logic accept;

   assign busy   = (state_ff != prlt_pkg::ST_IDLE);
   assign accept = start && (state_ff == prlt_pkg::ST_IDLE);

   // latched transaction
   logic [1:0]  mode_ff;
   logic [31:0] ip_ff;
   logic [63:0] now_ff, age_ff;
   logic        had_start_ff;

   // scan control
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             proc_ff, proc_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;

   // search results
   logic             hit_ff, hit_in, free_ff, free_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] lru_idx_ff, lru_idx_in;
   logic [63:0]      best_ff, best_in;

   // chosen entry working values
   logic [IDX_W-1:0] k_ff, k_in, pick;
   logic [7:0]       f_ff, f_in;
   logic [63:0]      hs_ff, hs_in;
   logic [31:0]      tmo_ff, tmo_in;

   // table memory, valid bits and registered read
   prlt_pkg::entry_type  mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] vld_ff;
   prlt_pkg::entry_type  rd_data_ff, ent, wr_data;
   logic                 rd_vld_ff, mem_we;
   logic [IDX_W-1:0]     rd_addr, wr_addr;

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_new_ff, rsp_new_in, rsp_timed_ff, rsp_timed_in;
   logic        rsp_ban_ff, rsp_ban_in;
   logic [7:0]  rsp_fail_ff, rsp_fail_in;
   logic [31:0] rsp_tmo_ff, rsp_tmo_in;
   logic [63:0] rsp_hs_ff, rsp_hs_in;

   // datapath helpers
   logic [63:0]      elapsed;
   logic             stale;
   logic [7:0]       fail_base;
   logic [31:0]      tier_tmo;
   logic             timed, ban, quick;
   logic [7:0]       new_fail;
   logic [63:0]      new_hs;
   logic [IDX_W+3:0] slot_ext;

   assign ent = rd_vld_ff ? rd_data_ff : '0;

   // shared compare work
   assign elapsed   = now_ff - ent.last_seen;
   assign stale     = (ent.failures != 8'd0) && (elapsed > prlt_pkg::STALE_LIMIT_US);
   assign pick      = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : lru_idx_ff);
   assign fail_base = hit_ff ? ent.failures : 8'd0;
   assign timed     = age_ff > {32'd0, tmo_ff};
   assign ban       = timed && (age_ff > {32'd0, ban_age_ff});
   assign quick     = age_ff <= {32'd0, tmo_base_ff};
   assign slot_ext  = {4'd0, k_ff};

   // tier selection: later tiers override earlier ones
   always_comb begin
      tier_tmo = tmo_base_ff;
      if (fail_base >= mid_lvl_ff)   tier_tmo = tmo_cong_ff;
      if (fail_base >= high_lvl_ff)  tier_tmo = tmo_hard_ff;
      if (fail_base >= flood_lvl_ff) tier_tmo = tmo_max_ff;
   end

   // failure / handshake update for the write-back stage
   always_comb begin
      new_fail = f_ff;
      new_hs   = hs_ff;
      if (mode_ff == prlt_pkg::MODE_CHECK) begin
         if (timed) begin
            new_hs = 64'd0;
            if (!ban && (f_ff != prlt_pkg::FAIL_SAT)) new_fail = f_ff + 8'd1;
         end
      end else if (had_start_ff) begin
         new_hs = age_ff;
         if (quick)              new_fail = 8'd0;
         else if (f_ff != 8'd0)  new_fail = f_ff - 8'd1;
      end else begin
         new_fail = 8'd0;
         new_hs   = 64'd0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prlt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == prlt_pkg::MODE_CHECK || req_mode == prlt_pkg::MODE_EST ||
                   req_mode == prlt_pkg::MODE_CLEAN) state_in = prlt_pkg::ST_SCAN;
               else state_in = prlt_pkg::ST_RESP;
            end
         end
         prlt_pkg::ST_SCAN: begin
            if (scan_ff == LAST_CNT) begin
               state_in = (mode_ff == prlt_pkg::MODE_CLEAN) ? prlt_pkg::ST_RESP
                                                            : prlt_pkg::ST_FETCH;
            end
         end
         prlt_pkg::ST_FETCH: state_in = prlt_pkg::ST_TIER;
         prlt_pkg::ST_TIER:  state_in = prlt_pkg::ST_FINAL;
         prlt_pkg::ST_FINAL: state_in = prlt_pkg::ST_IDLE;
         prlt_pkg::ST_RESP:  state_in = prlt_pkg::ST_IDLE;
         default:            state_in = prlt_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      scan_in     = scan_ff;
      proc_in     = 1'b0;
      proc_idx_in = proc_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      lru_idx_in  = lru_idx_ff;
      best_in     = best_ff;
      k_in        = k_ff;
      f_in        = f_ff;
      hs_in       = hs_ff;
      tmo_in      = tmo_ff;
      rd_addr     = scan_ff[IDX_W-1:0];
      mem_we      = 1'b0;
      wr_addr     = proc_idx_ff;
      wr_data     = '{address: 32'd0, last_seen: ent.last_seen, failures: 8'd0,
                      handshake: 64'd0};
      rsp_valid_in = 1'b0;
      rsp_slot_in  = 4'd0;
      rsp_new_in   = 1'b0;
      rsp_timed_in = 1'b0;
      rsp_ban_in   = 1'b0;
      rsp_fail_in  = 8'd0;
      rsp_tmo_in   = 32'd0;
      rsp_hs_in    = 64'd0;
      unique case (state_ff)
         prlt_pkg::ST_IDLE: begin
            if (accept) begin
               scan_in     = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               hit_idx_in  = '0;
               free_idx_in = '0;
               lru_idx_in  = '0;
               best_in     = prlt_pkg::NO_TIME;
            end
         end
         prlt_pkg::ST_SCAN: begin
            // issue one read per cycle, judge the entry read last cycle
            if (scan_ff != LAST_CNT) begin
               scan_in     = scan_ff + CNT_W'(1);
               proc_in     = 1'b1;
               proc_idx_in = scan_ff[IDX_W-1:0];
            end
            if (proc_ff) begin
               if (mode_ff == prlt_pkg::MODE_CLEAN) begin
                  mem_we = stale;
               end else begin
                  if (!hit_ff && (ent.address == ip_ff)) begin
                     hit_in     = 1'b1;
                     hit_idx_in = proc_idx_ff;
                  end
                  if (!free_ff && (ent.address == 32'd0)) begin
                     free_in     = 1'b1;
                     free_idx_in = proc_idx_ff;
                  end
                  if (ent.last_seen < best_ff) begin
                     best_in    = ent.last_seen;
                     lru_idx_in = proc_idx_ff;
                  end
               end
            end
         end
         prlt_pkg::ST_FETCH: begin
            k_in    = pick;
            rd_addr = pick;
         end
         prlt_pkg::ST_TIER: begin
            // a claimed entry starts with no failures but keeps its handshake
            f_in   = fail_base;
            hs_in  = ent.handshake;
            tmo_in = tier_tmo;
         end
         prlt_pkg::ST_FINAL: begin
            mem_we       = 1'b1;
            wr_addr      = k_ff;
            wr_data      = '{address: ip_ff, last_seen: now_ff, failures: new_fail,
                             handshake: new_hs};
            rsp_valid_in = 1'b1;
            rsp_slot_in  = slot_ext[3:0];
            rsp_new_in   = !hit_ff;
            rsp_fail_in  = new_fail;
            rsp_hs_in    = new_hs;
            if (mode_ff == prlt_pkg::MODE_CHECK) begin
               rsp_timed_in = timed;
               rsp_ban_in   = ban;
               rsp_tmo_in   = tmo_ff;
            end
         end
         prlt_pkg::ST_RESP: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prlt_pkg::ST_IDLE;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) vld_ff[wr_addr] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= req_mode;
         ip_ff        <= req_peer_ip;
         now_ff       <= req_now_us;
         age_ff       <= req_handshake_age_us;
         had_start_ff <= req_had_start;
      end
      scan_ff     <= scan_in;
      proc_idx_ff <= proc_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      lru_idx_ff  <= lru_idx_in;
      best_ff     <= best_in;
      k_ff        <= k_in;
      f_ff        <= f_in;
      hs_ff       <= hs_in;
      tmo_ff      <= tmo_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_timed_ff <= rsp_timed_in;
      rsp_ban_ff   <= rsp_ban_in;
      rsp_fail_ff  <= rsp_fail_in;
      rsp_tmo_ff   <= rsp_tmo_in;
      rsp_hs_ff    <= rsp_hs_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_slot                = rsp_slot_ff;
   assign rsp_was_new             = rsp_new_ff;
   assign rsp_timed_out           = rsp_timed_ff;
   assign rsp_ban_request         = rsp_ban_ff;
   assign rsp_fail_count          = rsp_fail_ff;
   assign rsp_timeout_used_us     = rsp_tmo_ff;
   assign rsp_stored_handshake_us = rsp_hs_ff;

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
   `ASSERT_NEXT(a_final_strobe, state_ff == prlt_pkg::ST_FINAL, rsp_valid_ff, "write-back without response strobe")
   `ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff, "response strobe lasted more than one cycle")
   `ASSERT_IMPLIES(a_write_state, mem_we, state_ff == prlt_pkg::ST_SCAN || state_ff == prlt_pkg::ST_FINAL, "table written outside scan or write-back")
   `ASSERT_IMPLIES(a_ban_timed, rsp_valid_ff && rsp_ban_ff, rsp_timed_ff, "ban requested without timeout")

endmodule

`default_nettype wire
